// File: hw/rtl/sorted_table_insert_remove_assert.svh
// ----------------------------------------------------------------------------
// Sorted table assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_REMOVE_ASSERT_SVH
`define SORTED_TABLE_INSERT_REMOVE_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define STIR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sorted table assertion failed");
// condition must never be seen outside reset
`define STIR_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("sorted table forbidden condition");
`else
`define STIR_ASSERT(lbl, clk, rstn, prop)
`define STIR_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: hw/rtl/stir_pkg.sv
// ----------------------------------------------------------------------------
// Sorted table package
// Field widths, codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package stir_pkg;

  localparam int KeyW        = 16;
  localparam int TagW        = 16;
  localparam int PosW        = 5;
  localparam int CmdW        = 2;
  localparam int StatusW     = 2;
  localparam int Capacity    = 32;
  localparam int MaxResults  = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LIST   = 2'd2,
    CMD_NONE   = 2'd3
  } stir_cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } stir_status_e;

  // per-cycle operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ROTATE = 2'd3
  } stir_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LIST = 1'b1
  } stir_state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } stir_entry_t;

  typedef struct packed {
    stir_op_e        op;
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } stir_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/stir_if.sv
// ----------------------------------------------------------------------------
// Sorted table channels
// Command channel and result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface stir_in_if;
  import stir_pkg::*;

  logic                valid;
  logic                ready;
  logic [CmdW-1:0]     cmd;
  logic [KeyW-1:0]     key;
  logic [TagW-1:0]     tag;

  modport source (output valid, cmd, key, tag, input ready);
  modport sink   (input valid, cmd, key, tag, output ready);
endinterface

interface stir_out_if;
  import stir_pkg::*;

  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [KeyW-1:0]     key_out;
  logic [TagW-1:0]     tag_out;
  logic [PosW-1:0]     position;
  logic                last;

  modport source (output valid, status, key_out, tag_out, position, last, input ready);
  modport sink   (input valid, status, key_out, tag_out, position, last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sorted_table_insert_remove.sv
// ----------------------------------------------------------------------------
// Sorted table with insert, remove and list
// Row of cells holding entries in ascending key order.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents                         | notes
//  --------+-----+---------------------------------------+----------------------
//  in_i    | in  | cmd, key, tag                         | one beat per command
//  out_o   | out | status, key_out, tag_out, position,   | one beat per insert/
//          |     | last                                  | remove/empty list, else one per shown entry
//
//  On insert and remove every cell compares its key with the command key at
//  once, and the row shifts toward the neighbors at the same clock edge.
//  List rotates the occupied cells one step per cycle, emitting cell 0; a
//  stalled result beat holds the rotation. A full pass leaves the row in its
//  original order. No command is taken while a list is draining.
//  Reset clears the entry count, the control state and the result valid; cell
//  contents are never read past the count.
//  A stalled result beat holds; a new command is taken when the output
//  register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_table_insert_remove_assert.svh"

module sorted_table_insert_remove #(
  parameter int Capacity = stir_pkg::Capacity
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  stir_in_if.sink     in_i,
  stir_out_if.source  out_o
);
  import stir_pkg::*;

  localparam int CntW = $clog2(Capacity+1);

  // cell row
  stir_entry_t        cell_entry [Capacity];
  logic [Capacity-1:0] cell_right;
  logic [Capacity-1:0] cell_match;
  stir_ctl_t          ctl;
  stir_op_e           op_c;
  logic               found;

  // control
  stir_state_e        state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    idx_inc;

  // result register
  logic               out_valid_q, out_valid_d;
  stir_status_e       status_q, status_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [TagW-1:0]    tag_q, tag_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic               last_q, last_d;

  logic               slot_free;
  logic               accept;
  logic               emit;
  logic               last_emit;
  stir_cmd_e          cmd;

  assign ctl   = '{op: op_c, key: in_i.key, tag: in_i.tag};
  assign found = |cell_match;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    stir_cell #(
      .Capacity (Capacity),
      .Idx      (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .count_i      (count_q),
      .found_i      (found),
      .prev_right_i ((i == 0) ? 1'b0 : cell_right[(i == 0) ? 0 : i-1]),
      .prev_i       (cell_entry[(i == 0) ? 0 : i-1]),
      .next_i       (cell_entry[(i == Capacity-1) ? i : i+1]),
      .head_i       (cell_entry[0]),
      .entry_o      (cell_entry[i]),
      .right_o      (cell_right[i]),
      .match_o      (cell_match[i])
    );
  end

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && slot_free;
  assign accept     = in_i.valid && in_i.ready;
  assign cmd        = stir_cmd_e'(in_i.cmd);
  assign idx_inc    = idx_q + CntW'(1);

  // only the first MaxResults entries are shown; the rest still rotate back
  assign emit      = 32'(idx_q) < 32'(MaxResults);
  assign last_emit = (idx_inc == count_q) || (32'(idx_inc) == 32'(MaxResults));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    op_c        = OP_HOLD;
    out_valid_d = out_valid_q && !out_o.ready;
    status_d    = status_q;
    key_d       = key_q;
    tag_d       = tag_q;
    pos_d       = pos_q;
    last_d      = last_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d  = '0;
          tag_d  = '0;
          pos_d  = '0;
          last_d = 1'b1;
          case (cmd)
            CMD_INSERT: begin
              out_valid_d = 1'b1;
              if (count_q == CntW'(Capacity)) begin
                status_d = ST_FULL;
              end else begin
                status_d = ST_OK;
                op_c     = OP_INSERT;
                count_d  = count_q + CntW'(1);
              end
            end
            CMD_REMOVE: begin
              out_valid_d = 1'b1;
              if (found) begin
                status_d = ST_OK;
                op_c     = OP_REMOVE;
                count_d  = count_q - CntW'(1);
              end else begin
                status_d = ST_NOT_FOUND;
              end
            end
            CMD_LIST: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                status_d    = ST_EMPTY;
              end else begin
                state_d = S_LIST;
                idx_d   = '0;
              end
            end
            default: begin
              // unused code: no result, no change
              out_valid_d = out_valid_q && !out_o.ready;
            end
          endcase
        end
      end
      S_LIST: begin
        if (slot_free || !emit) begin
          op_c  = OP_ROTATE;
          idx_d = idx_inc;
          if (emit) begin
            out_valid_d = 1'b1;
            status_d    = ST_OK;
            key_d       = cell_entry[0].key;
            tag_d       = cell_entry[0].tag;
            pos_d       = PosW'(idx_q);
            last_d      = last_emit;
          end
          if (idx_inc == count_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    key_q    <= key_d;
    tag_q    <= tag_d;
    pos_q    <= pos_d;
    last_q   <= last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = status_q;
  assign out_o.key_out  = key_q;
  assign out_o.tag_out  = tag_q;
  assign out_o.position = pos_q;
  assign out_o.last     = last_q;

  `STIR_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(Capacity))
  `STIR_ASSERT(a_list_blocks_in, clk_i, rst_ni, (state_q == S_LIST) |-> !in_i.ready)
  `STIR_ASSERT(a_list_nonempty, clk_i, rst_ni, (state_q == S_LIST) |-> (count_q != '0))
  `STIR_ASSERT(a_count_step, clk_i, rst_ni,
               (count_q == $past(count_q)) || (count_q == $past(count_q) + CntW'(1)) ||
               (count_q + CntW'(1) == $past(count_q)))

endmodule

`default_nettype wire

// File: hw/rtl/stir_cell.sv
// ----------------------------------------------------------------------------
// Sorted table cell
// One table slot: compare against the broadcast key and shift with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module stir_cell #(
  parameter int Capacity = stir_pkg::Capacity,
  parameter int Idx      = 0
) (
  input  wire logic                               clk_i,
  input  wire stir_pkg::stir_ctl_t                ctl_i,
  input  wire logic [$clog2(Capacity+1)-1:0]      count_i,
  input  wire logic                               found_i,
  input  wire logic                               prev_right_i,
  input  wire stir_pkg::stir_entry_t              prev_i,
  input  wire stir_pkg::stir_entry_t              next_i,
  input  wire stir_pkg::stir_entry_t              head_i,
  output      stir_pkg::stir_entry_t              entry_o,
  output      logic                               right_o,
  output      logic                               match_o
);
  import stir_pkg::*;

  localparam int CntW = $clog2(Capacity+1);

  stir_entry_t entry_q, entry_d;
  logic        occ;
  logic        tail;

  assign occ  = CntW'(Idx) < count_i;
  assign tail = CntW'(Idx + 1) == count_i;
  // at or past the insert point; sorted order keeps this monotone along the row
  assign right_o = !occ || (entry_q.key >= ctl_i.key);
  assign match_o = occ && (entry_q.key == ctl_i.key);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.op)
      OP_INSERT: begin
        if (prev_right_i) begin
          entry_d = prev_i;
        end else if (right_o) begin
          entry_d = '{key: ctl_i.key, tag: ctl_i.tag};
        end
      end
      OP_REMOVE: begin
        if (found_i && right_o) begin
          entry_d = next_i;
        end
      end
      OP_ROTATE: begin
        if (tail) begin
          entry_d = head_i;
        end else if (occ) begin
          entry_d = next_i;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire
